FILE: rtl/core/thermistor_average_beta_convert_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the thermistor conversion block.
// ----------------------------------------------------------------------------
`ifndef THERMISTOR_AVERAGE_BETA_CONVERT_DEFINES_SVH
`define THERMISTOR_AVERAGE_BETA_CONVERT_DEFINES_SVH

// The consequent holds in the same cycle as the antecedent.
`define TABC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("thermistor conversion check failed");

// The consequent holds in the cycle after the antecedent.
`define TABC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("thermistor conversion check failed");

`endif

FILE: rtl/core/thbeta_pkg.sv
// ----------------------------------------------------------------------------
// thbeta_pkg
// Types and constants of the thermistor averaging and beta conversion block.
// ----------------------------------------------------------------------------
`default_nettype none

package thbeta_pkg;

   localparam int SAMPLES_DEF        = 10;
   localparam int ADC_FULL_SCALE_DEF = 1023;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;

   localparam logic [CSR_IDX_W-1:0] CSR_TO_GROUND = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SERIES_R  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NOMINAL_R = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_NOMINAL_T = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BETA      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET    = 3'd5;

   localparam logic        RST_TO_GROUND = 1'b1;
   localparam logic [19:0] RST_SERIES_R  = 20'd100000;
   localparam logic [19:0] RST_NOMINAL_R = 20'd10000;
   localparam logic [14:0] RST_NOMINAL_T = 15'd2500;
   localparam logic [13:0] RST_BETA      = 14'd3950;
   localparam logic [13:0] RST_OFFSET    = 14'd650;

   localparam logic [31:0] LN2_Q32      = 32'd2977044472;
   localparam logic [16:0] KELVIN_CENTI = 17'd27315;
   localparam logic [31:0] CENTI_SCALE  = 32'd100;

   localparam logic signed [15:0] TEMP_MAX = 16'sd30000;
   localparam logic signed [15:0] TEMP_MIN = -16'sd30000;

   localparam int LOG_INT_W  = 6;
   localparam int LOG_FRAC_W = 24;
   localparam int LOG_W      = LOG_INT_W + LOG_FRAC_W;
   localparam int Q_W        = 61;
   localparam int D_W        = 48;
   localparam int STEP_W     = 6;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLAMP,
      ST_NUM,
      ST_DEN,
      ST_NORM,
      ST_SQR,
      ST_LN,
      ST_B100,
      ST_TERM,
      ST_TB,
      ST_N,
      ST_DIV,
      ST_FIN,
      ST_OUT
   } state_type;

endpackage

`default_nettype wire

FILE: rtl/core/thermistor_average_beta_convert.sv
// After the last beat of a group, each logarithm is found by normalisation and by squaring
// steps on the shared 32x32 multiplier, then the restoring divider runs; the divider is
// skipped when the beta equation meets its pole. rsp_valid rises when the result is ready.
// Throughput: one beat per cycle within a group, no beats are taken while a group converts.
// Reset clears the sum, the count, the sequencer and loads the register defaults.
// ----------------------------------------------------------------------------
// thermistor_average_beta_convert
// Averages ADC samples of a thermistor divider and converts to hundredths of
// a degree with the beta equation, using one multiplier under a sequencer.
// ----------------------------------------------------------------------------
`default_nettype none
`include "thermistor_average_beta_convert_defines.svh"

module thermistor_average_beta_convert #(
   parameter int SAMPLES        = thbeta_pkg::SAMPLES_DEF,
   parameter int ADC_FULL_SCALE = thbeta_pkg::ADC_FULL_SCALE_DEF
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_stall,
   input  wire  [9:0]                         req_sample,
   output logic                               rsp_valid,
   input  wire                                rsp_stall,
   output logic signed [15:0]                 rsp_temperature_centi,
   output logic [13:0]                        rsp_clamped_sum,
   input  wire                                csr_wr_en,
   input  wire  [thbeta_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire  [thbeta_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int FULL    = SAMPLES * ADC_FULL_SCALE;
   localparam int HI      = (ADC_FULL_SCALE - 1) * SAMPLES;
   localparam int SUM_MAX = (FULL > SAMPLES * 1023) ? FULL : SAMPLES * 1023;
   localparam int SUM_W   = $clog2(SUM_MAX + 1);
   localparam int CNT_W   = $clog2(SAMPLES + 1);
   localparam int VW      = (20 + SUM_W > 32) ? 20 + SUM_W : 32;

   localparam logic [SUM_W-1:0] FULL_V = SUM_W'(FULL);
   localparam logic [SUM_W-1:0] LO_V   = SUM_W'(SAMPLES);
   localparam logic [SUM_W-1:0] HI_V   = SUM_W'(HI);
   localparam logic [CNT_W-1:0] LAST_V = CNT_W'(SAMPLES - 1);

   thbeta_pkg::state_type state_ff, state_in;

   logic        to_gnd_ff;
   logic [19:0] rs_ff, rn_ff;
   logic [14:0] ntc_ff;
   logic [13:0] beta_ff, off_ff;

   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [SUM_W-1:0] s_ff, s_in;
   logic             which_ff, which_in;
   logic [VW-1:0]    x_ff, x_in;
   logic [thbeta_pkg::LOG_INT_W-1:0]  p_ff, p_in;
   logic [31:0]                        m_ff, m_in;
   logic [thbeta_pkg::LOG_FRAC_W-1:0]  frac_ff, frac_in;
   logic [thbeta_pkg::STEP_W-1:0]      step_ff, step_in;
   logic [thbeta_pkg::LOG_W-1:0]       logn_ff, logn_in, logd_ff, logd_in;
   logic [29:0]                        lnmag_ff, lnmag_in;
   logic                               neg_ff, neg_in;
   logic [20:0]                        kb_ff, kb_in;
   logic signed [thbeta_pkg::D_W-1:0]  d_ff, d_in;
   logic [29:0]                        tb_ff, tb_in;
   logic [thbeta_pkg::Q_W-1:0]         q_ff, q_in;
   logic [46:0]                        rem_ff, rem_in;
   logic signed [15:0]                 temp_ff, temp_in;

   logic [31:0] mul_a, mul_b;
   logic [63:0] prod;
   logic [19:0] rs_eff, rn_eff;
   logic [SUM_W-1:0] comp_s;
   logic [15:0] t0;

   assign prod   = 64'(mul_a) * 64'(mul_b);
   assign rs_eff = (rs_ff == 20'd0) ? 20'd1 : rs_ff;
   assign rn_eff = (rn_ff == 20'd0) ? 20'd1 : rn_ff;
   assign comp_s = FULL_V - s_ff;
   assign t0     = 16'({{2{ntc_ff[14]}}, ntc_ff} + thbeta_pkg::KELVIN_CENTI);

   assign req_stall             = (state_ff != thbeta_pkg::ST_IDLE);
   assign rsp_valid             = (state_ff == thbeta_pkg::ST_OUT);
   assign rsp_temperature_centi = temp_ff;
   assign rsp_clamped_sum       = 14'(s_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= thbeta_pkg::ST_IDLE;
         sum_ff    <= '0;
         cnt_ff    <= '0;
         to_gnd_ff <= thbeta_pkg::RST_TO_GROUND;
         rs_ff     <= thbeta_pkg::RST_SERIES_R;
         rn_ff     <= thbeta_pkg::RST_NOMINAL_R;
         ntc_ff    <= thbeta_pkg::RST_NOMINAL_T;
         beta_ff   <= thbeta_pkg::RST_BETA;
         off_ff    <= thbeta_pkg::RST_OFFSET;
      end else begin
         state_ff <= state_in;
         sum_ff   <= sum_in;
         cnt_ff   <= cnt_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               thbeta_pkg::CSR_TO_GROUND: to_gnd_ff <= csr_wdata[0];
               thbeta_pkg::CSR_SERIES_R:  rs_ff     <= csr_wdata;
               thbeta_pkg::CSR_NOMINAL_R: rn_ff     <= csr_wdata;
               thbeta_pkg::CSR_NOMINAL_T: ntc_ff    <= csr_wdata[14:0];
               thbeta_pkg::CSR_BETA:      beta_ff   <= csr_wdata[13:0];
               thbeta_pkg::CSR_OFFSET:    off_ff    <= csr_wdata[13:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      s_ff     <= s_in;
      which_ff <= which_in;
      x_ff     <= x_in;
      p_ff     <= p_in;
      m_ff     <= m_in;
      frac_ff  <= frac_in;
      step_ff  <= step_in;
      logn_ff  <= logn_in;
      logd_ff  <= logd_in;
      lnmag_ff <= lnmag_in;
      neg_ff   <= neg_in;
      kb_ff    <= kb_in;
      d_ff     <= d_in;
      tb_ff    <= tb_in;
      q_ff     <= q_in;
      rem_ff   <= rem_in;
      temp_ff  <= temp_in;
   end

   always_comb begin
      logic signed [30:0] diff;
      logic [29:0]        mag;
      logic [63:0]        rnd;
      logic [45:0]        term;
      logic [47:0]        trial;
      logic               ge;
      logic signed [19:0] t20;

      state_in = state_ff;
      sum_in   = sum_ff;
      cnt_in   = cnt_ff;
      s_in     = s_ff;
      which_in = which_ff;
      x_in     = x_ff;
      p_in     = p_ff;
      m_in     = m_ff;
      frac_in  = frac_ff;
      step_in  = step_ff;
      logn_in  = logn_ff;
      logd_in  = logd_ff;
      lnmag_in = lnmag_ff;
      neg_in   = neg_ff;
      kb_in    = kb_ff;
      d_in     = d_ff;
      tb_in    = tb_ff;
      q_in     = q_ff;
      rem_in   = rem_ff;
      temp_in  = temp_ff;
      mul_a    = '0;
      mul_b    = '0;
      diff     = 31'({1'b0, logn_ff}) - 31'({1'b0, logd_ff});
      mag      = diff[30] ? 30'(-diff) : diff[29:0];
      rnd      = prod + 64'h0000_0000_8000_0000;
      term     = prod[45:0];
      trial    = {rem_ff, q_ff[thbeta_pkg::Q_W-1]};
      ge       = (trial >= {1'b0, d_ff[46:0]});
      t20      = $signed(20'(q_ff[16:0])) - $signed(20'(thbeta_pkg::KELVIN_CENTI))
                 + $signed({{6{off_ff[13]}}, off_ff});

      unique case (state_ff)
         thbeta_pkg::ST_IDLE: begin
            if (req_valid) begin
               sum_in = sum_ff + SUM_W'(req_sample);
               if (cnt_ff == LAST_V) begin
                  cnt_in   = '0;
                  state_in = thbeta_pkg::ST_CLAMP;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         thbeta_pkg::ST_CLAMP: begin
            s_in     = (sum_ff < LO_V) ? LO_V : ((sum_ff > HI_V) ? HI_V : sum_ff);
            sum_in   = '0;
            state_in = thbeta_pkg::ST_NUM;
         end
         thbeta_pkg::ST_NUM: begin
            mul_a    = 32'(rs_eff);
            mul_b    = 32'(to_gnd_ff ? comp_s : s_ff);
            x_in     = VW'(prod);
            p_in     = thbeta_pkg::LOG_INT_W'(VW - 1);
            which_in = 1'b0;
            state_in = thbeta_pkg::ST_NORM;
         end
         thbeta_pkg::ST_DEN: begin
            mul_a    = 32'(rn_eff);
            mul_b    = 32'(to_gnd_ff ? s_ff : comp_s);
            x_in     = VW'(prod);
            p_in     = thbeta_pkg::LOG_INT_W'(VW - 1);
            which_in = 1'b1;
            state_in = thbeta_pkg::ST_NORM;
         end
         thbeta_pkg::ST_NORM: begin
            if (x_ff[VW-1]) begin
               m_in     = x_ff[VW-1 -: 32];
               frac_in  = '0;
               step_in  = '0;
               state_in = thbeta_pkg::ST_SQR;
            end else if (x_ff[VW-1 -: 8] == 8'd0) begin
               x_in = x_ff << 8;
               p_in = p_ff - thbeta_pkg::LOG_INT_W'(8);
            end else begin
               x_in = x_ff << 1;
               p_in = p_ff - 1'b1;
            end
         end
         thbeta_pkg::ST_SQR: begin
            mul_a = m_ff;
            mul_b = m_ff;
            if (prod[63]) begin
               m_in    = prod[63:32];
               frac_in = {frac_ff[thbeta_pkg::LOG_FRAC_W-2:0], 1'b1};
            end else begin
               m_in    = prod[62:31];
               frac_in = {frac_ff[thbeta_pkg::LOG_FRAC_W-2:0], 1'b0};
            end
            step_in = step_ff + 1'b1;
            if (step_ff == thbeta_pkg::STEP_W'(thbeta_pkg::LOG_FRAC_W - 1)) begin
               if (which_ff) begin
                  logd_in  = {p_ff, frac_in};
                  state_in = thbeta_pkg::ST_LN;
               end else begin
                  logn_in  = {p_ff, frac_in};
                  state_in = thbeta_pkg::ST_DEN;
               end
            end
         end
         thbeta_pkg::ST_LN: begin
            mul_a    = 32'(mag);
            mul_b    = thbeta_pkg::LN2_Q32;
            lnmag_in = rnd[61:32];
            neg_in   = diff[30];
            state_in = thbeta_pkg::ST_B100;
         end
         thbeta_pkg::ST_B100: begin
            mul_a    = 32'(beta_ff);
            mul_b    = thbeta_pkg::CENTI_SCALE;
            kb_in    = prod[20:0];
            state_in = thbeta_pkg::ST_TERM;
         end
         thbeta_pkg::ST_TERM: begin
            mul_a = 32'(t0);
            mul_b = 32'(lnmag_ff);
            if (neg_ff) begin
               d_in = $signed(48'({kb_ff, 24'd0}) - 48'(term));
            end else begin
               d_in = $signed(48'({kb_ff, 24'd0}) + 48'(term));
            end
            state_in = thbeta_pkg::ST_TB;
         end
         thbeta_pkg::ST_TB: begin
            mul_a    = 32'(t0);
            mul_b    = 32'(beta_ff);
            tb_in    = prod[29:0];
            state_in = thbeta_pkg::ST_N;
         end
         thbeta_pkg::ST_N: begin
            mul_a = 32'(tb_ff);
            mul_b = thbeta_pkg::CENTI_SCALE;
            if (d_ff[thbeta_pkg::D_W-1] || (d_ff == '0)) begin
               temp_in  = thbeta_pkg::TEMP_MAX;
               state_in = thbeta_pkg::ST_OUT;
            end else begin
               q_in     = {prod[36:0], 24'd0} + thbeta_pkg::Q_W'(d_ff[46:1]);
               rem_in   = '0;
               step_in  = '0;
               state_in = thbeta_pkg::ST_DIV;
            end
         end
         thbeta_pkg::ST_DIV: begin
            rem_in  = ge ? 47'(trial - {1'b0, d_ff[46:0]}) : trial[46:0];
            q_in    = {q_ff[thbeta_pkg::Q_W-2:0], ge};
            step_in = step_ff + 1'b1;
            if (step_ff == thbeta_pkg::STEP_W'(thbeta_pkg::Q_W - 1)) begin
               state_in = thbeta_pkg::ST_FIN;
            end
         end
         thbeta_pkg::ST_FIN: begin
            if (|q_ff[thbeta_pkg::Q_W-1:17]) begin
               temp_in = thbeta_pkg::TEMP_MAX;
            end else if (t20 > 20'(thbeta_pkg::TEMP_MAX)) begin
               temp_in = thbeta_pkg::TEMP_MAX;
            end else if (t20 < 20'(thbeta_pkg::TEMP_MIN)) begin
               temp_in = thbeta_pkg::TEMP_MIN;
            end else begin
               temp_in = t20[15:0];
            end
            state_in = thbeta_pkg::ST_OUT;
         end
         thbeta_pkg::ST_OUT: begin
            if (!rsp_stall) begin
               state_in = thbeta_pkg::ST_IDLE;
            end
         end
         default: state_in = thbeta_pkg::ST_IDLE;
      endcase
   end

   `TABC_ASSERT_SAME(a_temp_range, clock, reset, rsp_valid,
      (rsp_temperature_centi <= thbeta_pkg::TEMP_MAX) &&
      (rsp_temperature_centi >= thbeta_pkg::TEMP_MIN))
   `TABC_ASSERT_SAME(a_sum_clamped, clock, reset, rsp_valid,
      (s_ff >= LO_V) && (s_ff <= HI_V))
   `TABC_ASSERT_SAME(a_norm_nonzero, clock, reset,
      state_ff == thbeta_pkg::ST_NORM, x_ff != '0)
   `TABC_ASSERT_NEXT(a_group_start, clock, reset,
      req_valid && !req_stall && (cnt_ff == LAST_V), state_ff == thbeta_pkg::ST_CLAMP)

endmodule

`default_nettype wire

FILE: sim/thermistor_average_beta_convert_checker.sv
// ----------------------------------------------------------------------------
// thermistor_average_beta_convert_checker
// Watches the sample, result and register ports of the thermistor block,
// predicts each group result from the accepted beats and compares it field
// by field with what the block delivers.
// ----------------------------------------------------------------------------
`default_nettype none

module thermistor_average_beta_convert_checker
   import thbeta_pkg::*;
(
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   input  wire                   req_stall,
   input  wire  [9:0]            req_sample,
   input  wire                   rsp_valid,
   input  wire                   rsp_stall,
   input  wire  signed [15:0]    rsp_temperature_centi,
   input  wire  [13:0]           rsp_clamped_sum,
   input  wire                   csr_wr_en,
   input  wire  [CSR_IDX_W-1:0]  csr_index,
   input  wire  [CSR_DATA_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    pending
);

   typedef struct {
      logic signed [15:0] temp;
      logic [13:0]        sum;
   } group_result_t;

   localparam int GROUP = SAMPLES_DEF;
   localparam longint FULL = longint'(ADC_FULL_SCALE_DEF) * GROUP;

   group_result_t expected_groups[$];

   logic        to_ground;
   logic [19:0] series_r;
   logic [19:0] nominal_r;
   logic [14:0] nominal_t;
   logic [13:0] beta_k;
   logic [13:0] offset_c;
   int          acc_sum;
   int          acc_count;
   int          mismatches;

   function automatic logic [31:0] log2_q24(logic [63:0] v);
      int          p;
      logic [63:0] m;
      logic [31:0] frac;
      p = 0;
      while (p < 63 && (v >> (p + 1)) != 0)
         p++;
      if (p <= 31)
         m = v << (31 - p);
      else
         m = v >> (p - 31);
      frac = 0;
      for (int i = 0; i < 24; i++) begin
         m = m * m;
         frac = frac << 1;
         if (m[63]) begin
            frac[0] = 1'b1;
            m = m >> 32;
         end else begin
            m = m >> 31;
         end
      end
      return (32'(p) << 24) | frac;
   endfunction

   function automatic logic signed [15:0] temp_from_sum(longint s);
      logic [63:0] rs, rn, num, den, mag, lnmag;
      longint      diff, lnx, t0, b, d, n, t;
      rs = (series_r == 0) ? 64'd1 : 64'(series_r);
      rn = (nominal_r == 0) ? 64'd1 : 64'(nominal_r);
      if (to_ground) begin
         num = rs * 64'(FULL - s);
         den = 64'(s) * rn;
      end else begin
         num = rs * 64'(s);
         den = rn * 64'(FULL - s);
      end
      diff = longint'(log2_q24(num)) - longint'(log2_q24(den));
      mag = 64'(diff < 0 ? -diff : diff);
      lnmag = (mag * 64'(LN2_Q32) + (64'd1 << 31)) >> 32;
      lnx = diff < 0 ? -longint'(lnmag) : longint'(lnmag);
      t0 = longint'($signed(nominal_t)) + longint'(KELVIN_CENTI);
      b = longint'(beta_k);
      d = 100 * b * (longint'(1) << 24) + t0 * lnx;
      if (d <= 0)
         return TEMP_MAX;
      n = 100 * t0 * b * (longint'(1) << 24);
      t = (n + d / 2) / d;
      t = t - longint'(KELVIN_CENTI) + longint'($signed(offset_c));
      if (t > 30000)
         t = 30000;
      if (t < -30000)
         t = -30000;
      return 16'(t);
   endfunction

   assign pending = expected_groups.size();

   always @(posedge clock) begin
      group_result_t exp_res;
      longint        s;
      if (reset) begin
         to_ground = RST_TO_GROUND;
         series_r = RST_SERIES_R;
         nominal_r = RST_NOMINAL_R;
         nominal_t = RST_NOMINAL_T;
         beta_k = RST_BETA;
         offset_c = RST_OFFSET;
         acc_sum = 0;
         acc_count = 0;
         expected_groups.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_TO_GROUND: to_ground = csr_wdata[0];
               CSR_SERIES_R:  series_r = csr_wdata[19:0];
               CSR_NOMINAL_R: nominal_r = csr_wdata[19:0];
               CSR_NOMINAL_T: nominal_t = csr_wdata[14:0];
               CSR_BETA:      beta_k = csr_wdata[13:0];
               CSR_OFFSET:    offset_c = csr_wdata[13:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_groups.size() == 0) begin
               fail_count++;
               mismatches++;
               if (mismatches <= 10)
                  $display("Unexpected result beat: temp %0d sum %0d",
                           rsp_temperature_centi, rsp_clamped_sum);
            end else begin
               exp_res = expected_groups.pop_front();
               if (exp_res.temp !== rsp_temperature_centi
                   || exp_res.sum !== rsp_clamped_sum) begin
                  fail_count++;
                  mismatches++;
                  if (mismatches <= 10)
                     $display("Result mismatch: expected temp %0d sum %0d, got temp %0d sum %0d",
                              exp_res.temp, exp_res.sum, rsp_temperature_centi,
                              rsp_clamped_sum);
               end
            end
         end
         if (req_valid && !req_stall) begin
            acc_sum += int'(req_sample);
            acc_count++;
            if (acc_count >= GROUP) begin
               s = acc_sum;
               if (s < GROUP)
                  s = GROUP;
               if (s > longint'(ADC_FULL_SCALE_DEF - 1) * GROUP)
                  s = longint'(ADC_FULL_SCALE_DEF - 1) * GROUP;
               acc_sum = 0;
               acc_count = 0;
               exp_res.temp = temp_from_sum(s);
               exp_res.sum = 14'(s);
               expected_groups.push_back(exp_res);
            end
         end
      end
   end

   initial begin
      fail_count = 0;
      mismatches = 0;
   end

endmodule

`default_nettype wire

FILE: sim/tb_thermistor_average_beta_convert.sv
// ----------------------------------------------------------------------------
// tb_thermistor_average_beta_convert
// Drives groups of ADC samples through the thermistor block under a series of
// register settings, with random gaps and stalls on both channels, and gives
// the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_thermistor_average_beta_convert;
   import thbeta_pkg::*;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [9:0]            req_sample;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic signed [15:0]    rsp_temperature_centi;
   logic [13:0]           rsp_clamped_sum;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    fail_count;
   int                    pending;
   logic                  quiet;
   logic                  hold_off;
   int                    hold_cycles;

   thermistor_average_beta_convert dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_sample(req_sample),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_temperature_centi(rsp_temperature_centi),
      .rsp_clamped_sum(rsp_clamped_sum),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   thermistor_average_beta_convert_checker checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_sample(req_sample),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_temperature_centi(rsp_temperature_centi),
      .rsp_clamped_sum(rsp_clamped_sum),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending(pending)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   initial begin
      #40000000;
      $display("Verification failed");
      $finish;
   end

   // The receiver stalls at random, and once holds off for a long stretch
   // while samples keep coming, so that the block backs up into its input.
   initial begin
      rsp_stall = 1'b0;
      hold_cycles = 0;
      forever begin
         @(negedge clock);
         if (hold_off && hold_cycles < 800) begin
            hold_cycles++;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !quiet && ($urandom_range(99) < 14);
         end
      end
   end

   task automatic send_beat(input logic [9:0] v);
      while (!quiet && $urandom_range(99) < 14) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_sample <= v;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_group(input int shape);
      logic [9:0] v;
      for (int i = 0; i < SAMPLES_DEF; i++) begin
         case (shape)
            0: v = 10'd0;
            1: v = 10'd1023;
            2: v = (i % 2) ? 10'h2AA : 10'h155;
            3: v = 10'($urandom_range(40));
            4: v = 10'($urandom_range(1023, 985));
            default: v = 10'($urandom_range(1023));
         endcase
         send_beat(v);
      end
   endtask

   task automatic send_random_groups(input int count);
      int r;
      for (int g = 0; g < count; g++) begin
         r = $urandom_range(99);
         send_group(r < 12 ? 3 : (r < 24 ? 4 : 5));
      end
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0)
         @(negedge clock);
      repeat (160) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [19:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic write_all(input logic g, input logic [19:0] rs, input logic [19:0] rn,
                            input logic [14:0] t0, input logic [13:0] b,
                            input logic [13:0] off);
      write_reg(CSR_TO_GROUND, {19'd0, g});
      write_reg(CSR_SERIES_R, rs);
      write_reg(CSR_NOMINAL_R, rn);
      write_reg(CSR_NOMINAL_T, {5'd0, t0});
      write_reg(CSR_BETA, {6'd0, b});
      write_reg(CSR_OFFSET, {6'd0, off});
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_sample = '0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      quiet = 1'b0;
      hold_off = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_group(0);
      send_group(1);
      send_group(2);
      settle();

      send_random_groups(10);
      settle();
      write_all(1'b0, 20'd4700, 20'd4700, 15'd2500, 14'd3950, 14'd0);
      send_group(0);
      send_group(1);
      quiet = 1'b1;
      send_random_groups(10);
      quiet = 1'b0;
      settle();
      write_all(1'b1, 20'd0, 20'd0, 15'h4000, 14'd0, 14'h2000);
      send_random_groups(8);
      settle();
      write_all(1'b0, 20'hFFFFF, 20'd1, 15'h3FFF, 14'h3FFF, 14'h1FFF);
      send_group(0);
      send_group(1);
      send_random_groups(8);
      settle();
      write_all(1'b1, 20'd1, 20'hFFFFF, 15'h4000, 14'd1000, 14'h2C78);
      send_random_groups(8);
      settle();
      write_all(1'b0, 20'd1000000, 20'd1, 15'd15000, 14'd10000, 14'd5000);
      hold_off = 1'b1;
      send_random_groups(10);
      settle();

      for (int ph = 0; ph < 7; ph++) begin
         if (ph % 2)
            write_all(1'($urandom_range(1)), 20'($urandom), 20'($urandom),
                      15'($urandom), 14'($urandom), 14'($urandom));
         else
            write_all(1'($urandom_range(1)), 20'($urandom_range(1000000, 1)),
                      20'($urandom_range(1000000, 1)),
                      15'($urandom_range(20500) - 5500), 14'($urandom_range(10000, 1000)),
                      14'($urandom_range(10000) - 5000));
         send_random_groups(8);
         settle();
      end

      if (fail_count == 0 && pending == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

`default_nettype wire

FILE: thermistor_average_beta_convert.f
+incdir+rtl/core
rtl/core/thbeta_pkg.sv
rtl/core/thermistor_average_beta_convert.sv
sim/thermistor_average_beta_convert_checker.sv
sim/tb_thermistor_average_beta_convert.sv
